/* design/pwmf_pkg.sv */
package pwmf_pkg;

   localparam int MAX_BUFFER_BYTES_DEF = 65536;
   localparam int KEYWORD_BYTES        = 20;
   localparam int HANDSHAKE_BYTES      = 68;
   localparam int PREFIX_BYTES         = 4;
   localparam int SIZE_W               = 17;
   localparam int PREFIX_W             = 32;

   // length byte followed by the protocol string, first byte in the top bits
   localparam logic [8*KEYWORD_BYTES-1:0] KEYWORD = {8'd19, "BitTorrent protocol"};

   typedef enum logic [1:0] {
      KIND_HANDSHAKE = 2'd0,
      KIND_KEEPALIVE = 2'd1,
      KIND_TYPED     = 2'd2
   } kind_type;

   typedef struct packed {
      logic              message_done;
      kind_type          message_kind;
      logic [7:0]        message_id;
      logic [SIZE_W-1:0] message_bytes;
      logic              buffer_done;
      logic              buffer_complete;
      logic [SIZE_W-1:0] ok_length;
   } rsp_type;

   // keyword byte at position idx (0 is the length byte)
   function automatic logic [7:0] keyword_byte(input logic [4:0] idx);
      logic [7:0] res;
      res = 8'd0;
      if (idx < 5'(KEYWORD_BYTES)) begin
         res = KEYWORD[8*KEYWORD_BYTES - 1 - 8*int'(idx) -: 8];
      end
      return res;
   endfunction

endpackage

/* design/peer_wire_message_framer_top.sv */
// peer wire message framer
//
// req channel: one buffer byte per word (req_data_byte), req_end_of_buffer high
// on the last byte of a buffer. a word is taken when req_valid is high and
// req_stall is low. framing starts fresh after every last byte.
// rsp channel: one word per byte that completes a message and/or ends a
// buffer; bytes that do neither produce no word. message fields are zero when
// no message completed, buffer fields are zero when the buffer did not end.
// responses are registered (skid register behind a held word). throughput: one
// byte per cycle while req_stall is low, set by the single register-to-register
// pass that updates the framing counters and the response register.
// stall: the response register is backed by a one-word skid register, so input
// keeps flowing while one response waits; req_stall rises only once the skid
// register holds a word, and falls the cycle after the receiver takes one.
// bytes beyond MAX_BUFFER_BYTES in one buffer are dropped and that buffer
// reports itself incomplete.
// reset (synchronous, active high) empties both response registers and puts
// the framer at the start of a fresh buffer.
module peer_wire_message_framer_top #(
   parameter int MAX_BUFFER_BYTES = pwmf_pkg::MAX_BUFFER_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_end_of_buffer,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_message_done,
   output logic [1:0]                  rsp_message_kind,
   output logic [7:0]                  rsp_message_id,
   output logic [pwmf_pkg::SIZE_W-1:0] rsp_message_bytes,
   output logic                        rsp_buffer_done,
   output logic                        rsp_buffer_complete,
   output logic [pwmf_pkg::SIZE_W-1:0] rsp_ok_length
);
   import pwmf_pkg::*;

   // counters hold up to MAX_BUFFER_BYTES itself
   localparam int CNT_W  = $clog2(MAX_BUFFER_BYTES + 1);
   localparam int WIDE_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
   localparam int CMP_W  = PREFIX_W + 1;

   // framing state
   logic [CNT_W-1:0]    offset_ff, offset_in;         // bytes of this buffer taken
   logic [CNT_W-1:0]    complete_ff, complete_in;     // offset after last full message
   logic [CNT_W-1:0]    msg_cnt_ff, msg_cnt_in;       // bytes of current message
   logic                kw_match_ff, kw_match_in;
   logic [PREFIX_W-1:0] prefix_ff, prefix_in;
   logic [7:0]          id_ff, id_in;
   logic                overflow_ff, overflow_in;

   // response register and skid register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff, skid_in;

   // per-byte datapath
   logic             accept;
   logic             take;
   logic             emit;
   logic             ovf_now;
   logic [CNT_W-1:0] n;
   logic             kw_next;
   logic [PREFIX_W-1:0] prefix_next;
   logic [7:0]       id_next;
   logic             hs_path;
   logic             hs_done;
   logic             lp_done;
   logic             done;
   logic [CNT_W-1:0] size_cnt;
   logic [CNT_W-1:0] ok_cnt;
   logic [WIDE_W-1:0] size_wide;
   logic [WIDE_W-1:0] ok_wide;
   rsp_type          new_rsp;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = rsp_valid_ff && !rsp_stall;

   always_comb begin
      ovf_now = overflow_ff || (offset_ff >= CNT_W'(MAX_BUFFER_BYTES));
      n       = msg_cnt_ff + CNT_W'(1);

      // keyword compare on the first 20 bytes of a message
      kw_next = kw_match_ff;
      if (msg_cnt_ff < CNT_W'(KEYWORD_BYTES) &&
          req_data_byte != keyword_byte(msg_cnt_ff[4:0])) begin
         kw_next = 1'b0;
      end

      // big-endian length prefix, then the id byte
      prefix_next = prefix_ff;
      if (msg_cnt_ff < CNT_W'(PREFIX_BYTES)) begin
         prefix_next = {prefix_ff[PREFIX_W-9:0], req_data_byte};
      end
      id_next = id_ff;
      if (msg_cnt_ff == CNT_W'(PREFIX_BYTES)) begin
         id_next = req_data_byte;
      end

      hs_path = kw_next && (n >= CNT_W'(KEYWORD_BYTES));
      hs_done = hs_path && (n == CNT_W'(HANDSHAKE_BYTES));
      lp_done = !hs_path && (n >= CNT_W'(PREFIX_BYTES)) &&
                (CMP_W'(n) == ({1'b0, prefix_next} + CMP_W'(PREFIX_BYTES)));
      done    = !ovf_now && (hs_done || lp_done);

      size_cnt  = hs_done ? CNT_W'(HANDSHAKE_BYTES) : n;
      ok_cnt    = done ? (offset_ff + CNT_W'(1)) : complete_ff;
      size_wide = WIDE_W'(size_cnt);
      ok_wide   = WIDE_W'(ok_cnt);

      new_rsp = '0;
      if (done) begin
         new_rsp.message_done  = 1'b1;
         new_rsp.message_bytes = size_wide[SIZE_W-1:0];
         if (hs_done) begin
            new_rsp.message_kind = KIND_HANDSHAKE;
         end else if (prefix_next == '0) begin
            new_rsp.message_kind = KIND_KEEPALIVE;
         end else begin
            new_rsp.message_kind = KIND_TYPED;
            new_rsp.message_id   = id_next;
         end
      end
      if (req_end_of_buffer) begin
         new_rsp.buffer_done     = 1'b1;
         // after a completed message the message counter is back at zero
         new_rsp.buffer_complete = done;
         new_rsp.ok_length       = ok_wide[SIZE_W-1:0];
      end

      emit = accept && (done || req_end_of_buffer);

      // framing state next values
      offset_in   = offset_ff;
      complete_in = complete_ff;
      msg_cnt_in  = msg_cnt_ff;
      kw_match_in = kw_match_ff;
      prefix_in   = prefix_ff;
      id_in       = id_ff;
      overflow_in = overflow_ff;
      if (accept) begin
         if (ovf_now) begin
            overflow_in = 1'b1;
         end else begin
            offset_in = offset_ff + CNT_W'(1);
            if (done) begin
               complete_in = offset_ff + CNT_W'(1);
               msg_cnt_in  = '0;
               kw_match_in = 1'b1;
               prefix_in   = '0;
               id_in       = '0;
            end else begin
               msg_cnt_in  = n;
               kw_match_in = kw_next;
               prefix_in   = prefix_next;
               id_in       = id_next;
            end
         end
         // last byte: fresh buffer
         if (req_end_of_buffer) begin
            offset_in   = '0;
            complete_in = '0;
            msg_cnt_in  = '0;
            kw_match_in = 1'b1;
            prefix_in   = '0;
            id_in       = '0;
            overflow_in = 1'b0;
         end
      end

      // response register with skid behind it
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!rsp_valid_ff || take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = skid_ff;
            skid_valid_in = emit;
            skid_in       = new_rsp;
         end else begin
            rsp_valid_in = emit;
            rsp_in       = new_rsp;
         end
      end else if (emit) begin
         skid_valid_in = 1'b1;
         skid_in       = new_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= '0;
         complete_ff   <= '0;
         msg_cnt_ff    <= '0;
         kw_match_ff   <= 1'b1;
         prefix_ff     <= '0;
         id_ff         <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         offset_ff     <= offset_in;
         complete_ff   <= complete_in;
         msg_cnt_ff    <= msg_cnt_in;
         kw_match_ff   <= kw_match_in;
         prefix_ff     <= prefix_in;
         id_ff         <= id_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_message_done    = rsp_ff.message_done;
   assign rsp_message_kind    = rsp_ff.message_kind;
   assign rsp_message_id      = rsp_ff.message_id;
   assign rsp_message_bytes   = rsp_ff.message_bytes;
   assign rsp_buffer_done     = rsp_ff.buffer_done;
   assign rsp_buffer_complete = rsp_ff.buffer_complete;
   assign rsp_ok_length       = rsp_ff.ok_length;

   // skid register only fills behind a held response
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word without response word");

   // every response word reports a message or a buffer end
   a_rsp_has_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.message_done || rsp_ff.buffer_done))
      else $error("empty response word");

   // a taken last byte restarts framing
   a_buffer_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_buffer) |=>
         (offset_ff == '0 && msg_cnt_ff == '0 && !overflow_ff))
      else $error("framing not restarted after last byte");

   // a message never spans more bytes than the buffer has given
   a_msg_within_buffer: assert property (@(posedge clock) disable iff (reset)
      (msg_cnt_ff <= offset_ff) && (complete_ff <= offset_ff))
      else $error("message counter beyond buffer offset");

endmodule

/* tb/sv/peer_wire_message_framer_top_test.sv */
`timescale 1ns / 100ps

module peer_wire_message_framer_top_test;
   import pwmf_pkg::*;

   // small buffer limit so that oversized buffers are cheap to reach
   localparam int MAX_BUF = 300;

   // one byte waiting to be sent, with an optional hold until all reports are in
   typedef struct {
      logic [7:0] data;
      logic       eob;
      logic       drain_first;
   } byte_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_data_byte = 8'h00;
   logic                req_end_of_buffer = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_message_done;
   logic [1:0]          rsp_message_kind;
   logic [7:0]          rsp_message_id;
   logic [SIZE_W-1:0]   rsp_message_bytes;
   logic                rsp_buffer_done;
   logic                rsp_buffer_complete;
   logic [SIZE_W-1:0]   rsp_ok_length;

   peer_wire_message_framer_top #(
      .MAX_BUFFER_BYTES(MAX_BUF)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_end_of_buffer   (req_end_of_buffer),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_message_done    (rsp_message_done),
      .rsp_message_kind    (rsp_message_kind),
      .rsp_message_id      (rsp_message_id),
      .rsp_message_bytes   (rsp_message_bytes),
      .rsp_buffer_done     (rsp_buffer_done),
      .rsp_buffer_complete (rsp_buffer_complete),
      .rsp_ok_length       (rsp_ok_length)
   );

   always #1 clock = ~clock;

   // bytes still to send and frame reports still owed by the block
   byte_word_type byte_queue[$];
   rsp_type     frame_reports[$];
   int unsigned words_total;
   int unsigned words_taken = 0;
   int unsigned mismatches = 0;

   // stimulus builder bookkeeping
   int unsigned buf_bytes = 0;    // bytes queued in the buffer being built
   int unsigned counted = 0;      // bytes that the block actually frames
   logic        hold_next = 1'b0; // next queued byte waits for a drained block

   // driver and monitor pacing
   byte_word_type cur_word;
   int unsigned send_gap = 0;
   int unsigned req_calm = 0;
   int unsigned stall_left = 0;
   int unsigned rsp_calm = 0;

   // framer state as seen by the predictor
   logic        kw_match;
   int unsigned msg_len;
   logic [31:0] prefix;
   logic [7:0]  cur_id;
   int unsigned buf_off;
   int unsigned done_off;
   logic        dropping;

   // ---------------------------------------------------------------
   // framing predictor
   // ---------------------------------------------------------------

   task automatic restart_message();
      kw_match = 1'b1;
      msg_len  = 0;
      prefix   = 32'h0;
      cur_id   = 8'h00;
   endtask

   task automatic clear_framer();
      restart_message();
      buf_off  = 0;
      done_off = 0;
      dropping = 1'b0;
   endtask

   // works out the report (if any) caused by one accepted byte
   task automatic frame_byte(input logic [7:0] b, input logic eob);
      int unsigned n;
      logic        hit;
      rsp_type     r;
      hit = 1'b0;
      r   = '0;
      if (dropping || buf_off >= MAX_BUF) begin
         // past the limit: byte is dropped and the buffer is marked bad
         dropping = 1'b1;
      end else begin
         n = msg_len + 1;
         buf_off++;
         if (n <= KEYWORD_BYTES && b != KEYWORD[8*(KEYWORD_BYTES - int'(n)) +: 8]) begin
            kw_match = 1'b0;
         end
         if (n <= PREFIX_BYTES) begin
            prefix = {prefix[23:0], b};
         end
         if (n == PREFIX_BYTES + 1) begin
            cur_id = b;
         end
         if (kw_match && n >= KEYWORD_BYTES) begin
            // keyword seen in full: only the handshake size can end it
            if (n == HANDSHAKE_BYTES) begin
               hit             = 1'b1;
               r.message_kind  = KIND_HANDSHAKE;
               r.message_bytes = SIZE_W'(HANDSHAKE_BYTES);
            end
         end else if (n >= PREFIX_BYTES &&
                      longint'(n) == longint'(prefix) + longint'(PREFIX_BYTES)) begin
            hit = 1'b1;
            if (prefix == 32'h0) begin
               r.message_kind = KIND_KEEPALIVE;
            end else begin
               r.message_kind = KIND_TYPED;
               r.message_id   = cur_id;
            end
            r.message_bytes = SIZE_W'(n);
         end
         if (hit) begin
            restart_message();
            done_off = buf_off;
         end else begin
            msg_len = n;
         end
      end
      if (hit || eob) begin
         r.message_done = hit;
         if (eob) begin
            r.buffer_done     = 1'b1;
            r.buffer_complete = !dropping && msg_len == 0;
            r.ok_length       = SIZE_W'(done_off);
            clear_framer();
         end
         frame_reports.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------
   // stimulus builders
   // ---------------------------------------------------------------

   task automatic push_byte(input logic [7:0] b);
      byte_word_type w;
      w.data        = b;
      w.eob         = 1'b0;
      w.drain_first = hold_next;
      hold_next     = 1'b0;
      byte_queue.push_back(w);
      if (buf_bytes < MAX_BUF) begin
         counted++;
      end
      buf_bytes++;
   endtask

   // marks the last queued byte as the end of the buffer
   task automatic close_buffer();
      byte_word_type w;
      if (buf_bytes == 0) begin
         push_byte(8'($urandom));
      end
      w     = byte_queue.pop_back();
      w.eob = 1'b1;
      byte_queue.push_back(w);
      buf_bytes = 0;
   endtask

   // length-prefixed message; cut limits how many of its bytes are queued
   task automatic put_length_msg(input logic [31:0] len, input logic [7:0] id,
                                 input int unsigned cut);
      int unsigned i;
      for (i = 0; i < cut; i++) begin
         if (i < PREFIX_BYTES) begin
            push_byte(len[8*(PREFIX_BYTES - 1 - i) +: 8]);
         end else if (i == PREFIX_BYTES) begin
            push_byte(id);
         end else begin
            push_byte(8'($urandom));
         end
      end
   endtask

   // handshake: keyword then a random body, cut bytes of it queued
   task automatic put_handshake(input int unsigned cut);
      int unsigned i;
      for (i = 0; i < cut; i++) begin
         if (i < KEYWORD_BYTES) begin
            push_byte(KEYWORD[8*(KEYWORD_BYTES - 1 - i) +: 8]);
         end else begin
            push_byte(8'($urandom));
         end
      end
   endtask

   // mostly short gaps, a few long ones, and now and then a stretch with none
   function automatic int unsigned idle_len(inout int unsigned calm);
      int unsigned r;
      if (calm != 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r == 0) begin
         calm = $urandom_range(40, 160);
         return 0;
      end
      if (r < 110) return 0;
      if (r < 170) return $urandom_range(1, 3);
      if (r < 194) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic flag_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch at %0t on %s: got %0h, want %0h", $realtime, field, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------
   // driver: one byte word per handshake, paced by random gaps
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_framer();
      end else begin
         // a word taken at this edge gets its report predicted now
         if (req_valid && !req_stall) begin
            frame_byte(req_data_byte, req_end_of_buffer);
            words_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (byte_queue.size() == 0 ||
                         (byte_queue[0].drain_first && frame_reports.size() != 0)) begin
               // out of bytes, or holding off until every report is back
               req_valid <= 1'b0;
            end else begin
               cur_word          = byte_queue.pop_front();
               req_valid         <= 1'b1;
               req_data_byte     <= cur_word.data;
               req_end_of_buffer <= cur_word.eob;
               send_gap          = idle_len(req_calm);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: random stall, each report checked against the oldest owed
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_reports.size() == 0) begin
               flag_mismatch("report with none owed", 32'd1, 32'd0);
            end else begin
               want = frame_reports.pop_front();
               if (rsp_message_done !== want.message_done)
                  flag_mismatch("message_done", rsp_message_done, want.message_done);
               if (rsp_message_kind !== want.message_kind)
                  flag_mismatch("message_kind", rsp_message_kind, want.message_kind);
               if (rsp_message_id !== want.message_id)
                  flag_mismatch("message_id", rsp_message_id, want.message_id);
               if (rsp_message_bytes !== want.message_bytes)
                  flag_mismatch("message_bytes", rsp_message_bytes, want.message_bytes);
               if (rsp_buffer_done !== want.buffer_done)
                  flag_mismatch("buffer_done", rsp_buffer_done, want.buffer_done);
               if (rsp_buffer_complete !== want.buffer_complete)
                  flag_mismatch("buffer_complete", rsp_buffer_complete,
                                want.buffer_complete);
               if (rsp_ok_length !== want.ok_length)
                  flag_mismatch("ok_length", rsp_ok_length, want.ok_length);
            end
         end
         // stall decided independently of rsp_valid
         if (stall_left == 0 && $urandom_range(0, 2) == 0) begin
            stall_left = idle_len(rsp_calm);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) begin
            stall_left--;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------
   initial begin
      int unsigned buf_no;
      int unsigned n_msgs;
      int unsigned pick;
      int unsigned k;
      int unsigned len;
      int unsigned rem;
      int unsigned pos;
      int unsigned variant;

      // directed: keep-alive that ends its buffer on the same byte
      put_length_msg(32'd0, 8'h00, 4);
      close_buffer();
      // shortest typed message with the top id, then a one-byte partial tail
      put_length_msg(32'd1, 8'hff, 5);
      push_byte(8'hff);
      close_buffer();
      // buffer of one zero byte: nothing completes
      push_byte(8'h00);
      close_buffer();
      // typed message with id zero followed by a keep-alive
      put_length_msg(32'd2, 8'h00, 6);
      put_length_msg(32'd0, 8'h00, 4);
      close_buffer();
      // keyword start cut short: length byte, 'B', 'i'
      push_byte(8'd19);
      push_byte(8'h42);
      push_byte(8'h69);
      close_buffer();

      // random buffers: well-formed messages with random content, broken tails
      hold_next = 1'b1;
      buf_no    = 0;
      while (counted < 1900) begin
         if (buf_no % 7 == 3) begin
            hold_next = 1'b1;
         end
         if (buf_no % 9 == 4) begin
            // buffer that reaches the size limit
            variant = (buf_no / 9) % 3;
            while (MAX_BUF - buf_bytes > 133) begin
               if ($urandom_range(0, 3) == 0) begin
                  put_handshake(HANDSHAKE_BYTES);
               end else begin
                  len = $urandom_range(1, 120);
                  put_length_msg(len, 8'($urandom), len + 4);
               end
            end
            rem = MAX_BUF - buf_bytes;
            case (variant)
               0: put_length_msg(rem - 4, 8'($urandom), rem);
               1: begin
                  // exactly full, then bytes that must be dropped
                  put_length_msg(rem - 4, 8'($urandom), rem);
                  repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
               end
               default: put_length_msg(rem + 6, 8'($urandom), rem + 10);
            endcase
         end else begin
            n_msgs = $urandom_range(1, 6);
            for (k = 0; k < n_msgs && buf_bytes < 100; k++) begin
               pick = $urandom_range(0, 99);
               if (pick < 25) begin
                  put_handshake(HANDSHAKE_BYTES);
               end else if (pick < 40) begin
                  put_length_msg(32'd0, 8'h00, 4);
               end else begin
                  pick = $urandom_range(0, 99);
                  if (pick < 70) len = $urandom_range(1, 12);
                  else if (pick < 95) len = $urandom_range(13, 60);
                  else len = $urandom_range(61, 120);
                  put_length_msg(len, 8'($urandom), len + 4);
               end
            end
            pick = $urandom_range(0, 9);
            case (pick)
               5, 6: put_handshake($urandom_range(1, HANDSHAKE_BYTES - 1));
               7: begin
                  // typed message cut before its last byte
                  len = $urandom_range(1, 40);
                  put_length_msg(len, 8'($urandom), $urandom_range(1, len + 3));
               end
               8: begin
                  // keyword with one wrong byte, then a few more
                  pos = $urandom_range(0, KEYWORD_BYTES - 1);
                  for (k = 0; k <= pos; k++) begin
                     if (k == pos)
                        push_byte(KEYWORD[8*(KEYWORD_BYTES - 1 - k) +: 8] ^
                                  8'($urandom_range(1, 255)));
                     else
                        push_byte(KEYWORD[8*(KEYWORD_BYTES - 1 - k) +: 8]);
                  end
                  repeat ($urandom_range(0, 5)) push_byte(8'($urandom));
               end
               9: repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
               default: ; // buffer ends on a message boundary
            endcase
         end
         close_buffer();
         buf_no++;
      end
      words_total = byte_queue.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // every byte taken and every report back
      while (words_taken != words_total || frame_reports.size() != 0) begin
         @(posedge clock);
      end
      // then wait on to catch stray reports
      repeat (10) @(posedge clock);
      if (mismatches == 0 && frame_reports.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #3000000;
      $display("FAIL");
      $finish;
   end

endmodule

/* files.f */
design/pwmf_pkg.sv
design/peer_wire_message_framer_top.sv
tb/sv/peer_wire_message_framer_top_test.sv
